[rtl/wsas_pkg.sv]
`default_nettype none

package wsas_pkg;

  localparam int STATE_W      = 4;
  localparam int NUM_STATES   = 1 << STATE_W;
  localparam int MAX_WINDOW   = 32;
  localparam int MIN_WINDOW   = 2;
  localparam int WIN_IDX_W    = $clog2(MAX_WINDOW);
  localparam int LEN_W        = 6;
  localparam int FILL_W       = $clog2(MAX_WINDOW + 1);
  localparam int COUNT_W      = 5;
  localparam int TRANS_ADDR_W = 2 * STATE_W;
  localparam int NUM_TRANS    = NUM_STATES * NUM_STATES;
  localparam int HITS_W       = 6;
  localparam int REF_W        = 6;
  localparam int THR_W        = 17;
  localparam int FRAC_W       = 16;
  localparam int RATING_W     = 22;
  localparam int DIV_STEPS    = RATING_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int FUNC_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 17;

  localparam logic [RATING_W-1:0] Q16_ONE = RATING_W'(1) << FRAC_W;

  localparam logic [LEN_W-1:0] WIN_LEN_RESET = LEN_W'(32);
  localparam logic [REF_W-1:0] REF_HITS_RESET = REF_W'(33);
  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(32768);

  localparam logic [FUNC_W-1:0] FUNC_SAMPLE     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_COUNT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_FLAGS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_HITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_THRESHOLD = 2'd2;

  typedef struct packed {
    logic accept;
    logic init;
    logic step;
    logic div_init;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic score_req;
    logic last_step;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/wsas_if.sv]
`default_nettype none

interface wsas_in_if;
  logic                           valid;
  logic                           ready;
  logic [wsas_pkg::FUNC_W-1:0]    func;
  logic [wsas_pkg::STATE_W-1:0]   state_value;
  logic [wsas_pkg::STATE_W-1:0]   target_state;
  logic [wsas_pkg::COUNT_W-1:0]   count_value;
  logic                           start_flag;
  logic                           end_flag;

  modport source (output valid, func, state_value, target_state, count_value, start_flag,
                  end_flag, input ready);
  modport sink (input valid, func, state_value, target_state, count_value, start_flag,
                end_flag, output ready);
endinterface

interface wsas_out_if;
  logic                           valid;
  logic                           ready;
  logic [wsas_pkg::HITS_W-1:0]    hit_count;
  logic [wsas_pkg::HITS_W-1:0]    miss_count;
  logic [wsas_pkg::RATING_W-1:0]  rating;
  logic                           accepted;

  modport source (output valid, hit_count, miss_count, rating, accepted, input ready);
  modport sink (input valid, hit_count, miss_count, rating, accepted, output ready);
endinterface

interface wsas_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wsas_pkg::CFG_IDX_W-1:0]  index;
  logic [wsas_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/wsas_ctrl.sv]
`default_nettype none

module wsas_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  wsas_pkg::dp_status_t   status_i,
  output wsas_pkg::ctrl_cmd_t    cmd_o
);
  import wsas_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_DRAIN,
    S_DIV_LOAD,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;
  logic   accept;

  assign accept     = in_valid_i && in_ready_q;
  assign in_ready_o = in_ready_q;

  always_comb begin
    state_d    = state_q;
    in_ready_d = in_ready_q;
    case (state_q)
      S_IDLE: begin
        if (accept && status_i.score_req) begin
          state_d    = S_INIT;
          in_ready_d = 1'b0;
        end
      end
      S_INIT: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.last_step) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          state_d    = S_IDLE;
          in_ready_d = 1'b1;
        end
      end
      default: begin
        state_d    = S_IDLE;
        in_ready_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= in_ready_d;
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.init     = (state_q == S_INIT);
    cmd_o.step     = (state_q == S_SCAN);
    cmd_o.div_init = (state_q == S_DIV_LOAD);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.load_out = (state_q == S_OUT) && status_i.out_free;
  end

`ifndef ASSERT_OFF
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_q |-> state_q == S_IDLE)
    else $error("input ready raised outside idle");

  a_scored_sample_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status_i.score_req |=> !in_ready_q && state_q == S_INIT)
    else $error("scored sample did not start a scoring pass");
`endif

endmodule

`default_nettype wire

[rtl/wsas_datapath.sv]
`default_nettype none

module wsas_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wsas_pkg::ctrl_cmd_t               cmd_i,
  output wsas_pkg::dp_status_t              status_o,
  input  logic [wsas_pkg::FUNC_W-1:0]       func_i,
  input  logic [wsas_pkg::STATE_W-1:0]      state_value_i,
  input  logic [wsas_pkg::STATE_W-1:0]      target_state_i,
  input  logic [wsas_pkg::COUNT_W-1:0]      count_value_i,
  input  logic                              start_flag_i,
  input  logic                              end_flag_i,
  input  logic                              cfg_we_i,
  input  logic [wsas_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wsas_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              res_ready_i,
  output logic                              res_valid_o,
  output logic [wsas_pkg::HITS_W-1:0]       hit_count_o,
  output logic [wsas_pkg::HITS_W-1:0]       miss_count_o,
  output logic [wsas_pkg::RATING_W-1:0]     rating_o,
  output logic                              accepted_o
);
  import wsas_pkg::*;

  // Configuration registers.
  logic [LEN_W-1:0] win_len_q;
  logic [REF_W-1:0] ref_hits_q;
  logic [THR_W-1:0] threshold_q;

  // Window, automaton and scoring state.
  logic [STATE_W-1:0]      sym_q [MAX_WINDOW];
  logic [FILL_W-1:0]       fill_q, fill_next;
  logic [NUM_STATES-1:0]   start_q, end_q;
  logic [COUNT_W-1:0]      cnt_mem [NUM_TRANS];
  logic [COUNT_W-1:0]      used_mem [NUM_TRANS];
  logic [NUM_TRANS-1:0]    cnt_vld_q, used_vld_q;

  logic [LEN_W-1:0]        eff_len;
  logic [WIN_IDX_W-1:0]    idx_q, idx_init, rd_idx;
  logic [STATE_W-1:0]      rd_sym, prev_q;
  logic [TRANS_ADDR_W-1:0] trans_addr, s2_addr_q, wr_addr_q;
  logic                    sample_acc;

  logic                    s2_valid_q, wr_valid_q;
  logic [COUNT_W-1:0]      cnt_rd_q, used_rd_q, wr_val_q;
  logic                    cnt_vld_rd_q, used_vld_rd_q;
  logic                    fwd, hit, start_hit, end_hit;
  logic [COUNT_W-1:0]      used_eff, cnt_eff, used_new;
  logic [HITS_W-1:0]       hits_q, misses_q, init_hits;

  logic [RATING_W-1:0]     dvd_q;
  logic [REF_W-1:0]        rem_q, divisor;
  logic [DIV_CNT_W-1:0]    div_cnt_q;
  logic [REF_W:0]          trial, diff;
  logic                    trial_ge;

  logic                    out_valid_q;
  logic [HITS_W-1:0]       out_hits_q, out_misses_q;
  logic [RATING_W-1:0]     out_rating_q;
  logic                    out_accepted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= WIN_LEN_RESET;
      ref_hits_q  <= REF_HITS_RESET;
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW_LENGTH:    win_len_q   <= cfg_data_i[LEN_W-1:0];
        CFG_REFERENCE_HITS:   ref_hits_q  <= cfg_data_i[REF_W-1:0];
        CFG_ACCEPT_THRESHOLD: threshold_q <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (win_len_q < LEN_W'(MIN_WINDOW)) begin
      eff_len = LEN_W'(MIN_WINDOW);
    end else if (win_len_q > LEN_W'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = win_len_q;
    end
  end

  assign sample_acc = cmd_i.accept && (func_i == FUNC_SAMPLE);
  assign fill_next  = (fill_q == FILL_W'(MAX_WINDOW)) ? fill_q : fill_q + FILL_W'(1);

  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      sym_q[0] <= state_value_i;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        sym_q[i] <= sym_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      start_q   <= '0;
      end_q     <= '0;
      cnt_vld_q <= '0;
    end else if (cmd_i.accept) begin
      case (func_i)
        FUNC_SAMPLE: fill_q <= fill_next;
        FUNC_LOAD_COUNT: cnt_vld_q[{state_value_i, target_state_i}] <= 1'b1;
        FUNC_LOAD_FLAGS: begin
          start_q[state_value_i] <= start_flag_i;
          end_q[state_value_i]   <= end_flag_i;
        end
        default: ;
      endcase
    end
  end

  // The window is scanned from the oldest symbol toward the newest, one
  // transition per cycle, through a single read port on the shift line.
  assign idx_init   = WIN_IDX_W'(eff_len - LEN_W'(1));
  assign rd_idx     = cmd_i.init ? idx_init : idx_q - WIN_IDX_W'(1);
  assign rd_sym     = sym_q[rd_idx];
  assign trans_addr = {prev_q, rd_sym};
  assign start_hit  = start_q[rd_sym];
  assign end_hit    = end_q[sym_q[0]];
  assign init_hits  = HITS_W'(start_hit) + HITS_W'(end_hit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (func_i == FUNC_LOAD_COUNT)) begin
      cnt_mem[{state_value_i, target_state_i}] <= count_value_i;
    end
    if (s2_valid_q) begin
      used_mem[s2_addr_q] <= used_new;
    end
    if (cmd_i.step) begin
      cnt_rd_q  <= cnt_mem[trans_addr];
      used_rd_q <= used_mem[trans_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init || cmd_i.step) begin
      prev_q <= rd_sym;
      idx_q  <= rd_idx;
    end
    if (cmd_i.step) begin
      cnt_vld_rd_q  <= cnt_vld_q[trans_addr];
      used_vld_rd_q <= used_vld_q[trans_addr];
      s2_addr_q     <= trans_addr;
    end
    if (s2_valid_q) begin
      wr_addr_q <= s2_addr_q;
      wr_val_q  <= used_new;
    end
    if (cmd_i.init) begin
      hits_q   <= init_hits;
      misses_q <= HITS_W'(2) - init_hits;
    end else if (s2_valid_q) begin
      hits_q   <= hits_q + HITS_W'(hit);
      misses_q <= misses_q + HITS_W'(!hit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      wr_valid_q <= 1'b0;
      used_vld_q <= '0;
    end else begin
      s2_valid_q <= cmd_i.step;
      wr_valid_q <= s2_valid_q;
      if (cmd_i.init) begin
        used_vld_q <= '0;
      end else if (s2_valid_q) begin
        used_vld_q[s2_addr_q] <= 1'b1;
      end
    end
  end

  // The previous transition's write lands after this one's read was issued.
  assign fwd      = wr_valid_q && (wr_addr_q == s2_addr_q);
  assign used_eff = fwd ? wr_val_q : (used_vld_rd_q ? used_rd_q : '0);
  assign cnt_eff  = cnt_vld_rd_q ? cnt_rd_q : '0;
  assign hit      = used_eff < cnt_eff;
  assign used_new = used_eff + COUNT_W'(hit);

  // Restoring division of hits * 2^16 by the reference hit count.
  assign divisor  = (ref_hits_q == '0) ? REF_W'(1) : ref_hits_q;
  assign trial    = {rem_q, dvd_q[RATING_W-1]};
  assign trial_ge = trial >= {1'b0, divisor};
  assign diff     = trial - {1'b0, divisor};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dvd_q     <= {hits_q, FRAC_W'(0)};
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q     <= {dvd_q[RATING_W-2:0], trial_ge};
      rem_q     <= trial_ge ? diff[REF_W-1:0] : trial[REF_W-1:0];
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_hits_q     <= hits_q;
      out_misses_q   <= misses_q;
      out_rating_q   <= dvd_q;
      out_accepted_q <= (dvd_q >= RATING_W'(threshold_q)) && (dvd_q <= Q16_ONE);
    end
  end

  assign status_o.score_req = (func_i == FUNC_SAMPLE) && (fill_next >= FILL_W'(eff_len));
  assign status_o.last_step = (idx_q == WIN_IDX_W'(1));
  assign status_o.div_last  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign status_o.out_free  = !out_valid_q || res_ready_i;

  assign res_valid_o  = out_valid_q;
  assign hit_count_o  = out_hits_q;
  assign miss_count_o = out_misses_q;
  assign rating_o     = out_rating_q;
  assign accepted_o   = out_accepted_q;

`ifndef ASSERT_OFF
  a_check_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |-> ((LEN_W + 1)'(hits_q) + (LEN_W + 1)'(misses_q)
                        == (LEN_W + 1)'(eff_len) + (LEN_W + 1)'(1)))
    else $error("hit and miss totals do not cover the window");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> idx_q != '0)
    else $error("scan stepped past the newest symbol");

  a_accept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_accepted_q |-> out_rating_q <= Q16_ONE)
    else $error("accepted result rated above one");
`endif

endmodule

`default_nettype wire

[rtl/window_sequence_automaton_scorer_unit.sv]
`default_nettype none
// A sample that fills the window to the current length L starts a scoring pass: L - 1
// transition lookups, one per cycle on the count memory, then a 22-step restoring divider;
// the result is held until the output register is free. Loads and unscored samples are
// taken one per cycle while no pass runs. Reset clears counts and the output through valid
// bits, flags and fill directly, and sets the registers to 32, 33, 32768.

module window_sequence_automaton_scorer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsas_in_if.sink     in_i,
  wsas_out_if.source  res_o,
  wsas_cfg_if.sink    cfg_i
);
  import wsas_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  wsas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wsas_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .func_i         (in_i.func),
    .state_value_i  (in_i.state_value),
    .target_state_i (in_i.target_state),
    .count_value_i  (in_i.count_value),
    .start_flag_i   (in_i.start_flag),
    .end_flag_i     (in_i.end_flag),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .res_ready_i    (res_o.ready),
    .res_valid_o    (res_o.valid),
    .hit_count_o    (res_o.hit_count),
    .miss_count_o   (res_o.miss_count),
    .rating_o       (res_o.rating),
    .accepted_o     (res_o.accepted)
  );

endmodule

`default_nettype wire
